// ===== rtl/rotation_matrix_to_quaternion_top_assert.svh =====
// Assertion macros shared by the RTL of the matrix-to-quaternion block.
`ifndef ROTATION_MATRIX_TO_QUATERNION_TOP_ASSERT_SVH
`define ROTATION_MATRIX_TO_QUATERNION_TOP_ASSERT_SVH
`ifndef ASSERT_OFF
`define RMQ_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define RMQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define RMQ_ASSERT(lbl, clk, rst_n, prop, msg)
`define RMQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== rtl/rmq_pkg.sv =====
// ----------------------------------------------------------------------------
// rmq_pkg
// Widths, route codes and the classified word passed from front to back.
// ----------------------------------------------------------------------------
package rmq_pkg;

	localparam int W      = 16;
	localparam int F      = 14;
	localparam int ARG_W  = W + 1;
	localparam int SUM_W  = W + 3;
	localparam int D_W    = W + 1;
	localparam int MAG_W  = W + 1;
	localparam int SQ_N   = (ARG_W + F + 1) / 2;
	localparam int RAD_W  = 2 * SQ_N;
	localparam int S_W    = SQ_N;
	localparam int REM_W  = S_W + 3;
	localparam int DEN_W  = S_W + 1;
	localparam int QB     = W - 1;
	localparam int NUM_W  = MAG_W + F + 1;
	localparam int CMP_W  = (NUM_W > DEN_W + QB) ? NUM_W : DEN_W + QB;
	localparam int QDEPTH = 4;
	localparam int QA_W   = $clog2(QDEPTH);
	localparam int MAXV   = 2 ** (W - 1) - 1;

	// which output takes the halved root
	localparam logic [1:0] H_W = 2'd0;
	localparam logic [1:0] H_X = 2'd1;
	localparam logic [1:0] H_Y = 2'd2;
	localparam logic [1:0] H_Z = 2'd3;

	typedef struct packed {
		logic [ARG_W-1:0]        arg;
		logic signed [D_W-1:0]   d0;
		logic signed [D_W-1:0]   d1;
		logic signed [D_W-1:0]   d2;
		logic [1:0]              hsel;
	} cls_t;

endpackage

// ===== rtl/rotation_matrix_to_quaternion_top.sv =====
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion_top
// 3x3 rotation part in Q2.14 to unit quaternion (w,x,y,z) in Q2.14.
// ----------------------------------------------------------------------------
//  channel  | handshake      | payload
//  matrix   | push / full    | m00 .. m22, 16 bit signed
//  quat     | pop / empty    | quat_w .. quat_z, 16 bit signed; degenerate
//
// One word accepted per cycle while full is low. From push to empty low a word
// passes the queue, an entry register, the 16-stage root pipeline, a set-up
// stage, the 15-stage division pipeline and the output register.
// Reset clears the queue and all valid flags; no clearing pass.
// A held result stalls the whole back pipeline; the 4-word queue then fills
// and raises full.
module rotation_matrix_to_quaternion_top (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	output logic                         full,
	input  logic signed [rmq_pkg::W-1:0] m00,
	input  logic signed [rmq_pkg::W-1:0] m01,
	input  logic signed [rmq_pkg::W-1:0] m02,
	input  logic signed [rmq_pkg::W-1:0] m10,
	input  logic signed [rmq_pkg::W-1:0] m11,
	input  logic signed [rmq_pkg::W-1:0] m12,
	input  logic signed [rmq_pkg::W-1:0] m20,
	input  logic signed [rmq_pkg::W-1:0] m21,
	input  logic signed [rmq_pkg::W-1:0] m22,
	input  logic                         pop,
	output logic                         empty,
	output logic signed [rmq_pkg::W-1:0] quat_w,
	output logic signed [rmq_pkg::W-1:0] quat_x,
	output logic signed [rmq_pkg::W-1:0] quat_y,
	output logic signed [rmq_pkg::W-1:0] quat_z,
	output logic                         degenerate
);
	rmq_pkg::cls_t cls, qdata;
	logic          wr, qempty, qpop;

	assign wr = push && !full;

	rmq_front u_front (
		.m00(m00), .m01(m01), .m02(m02),
		.m10(m10), .m11(m11), .m12(m12),
		.m20(m20), .m21(m21), .m22(m22),
		.cls(cls)
	);

	rmq_queue u_queue (
		.clk(clk), .arst_n(arst_n),
		.wr(wr), .wdata(cls),
		.rd(qpop), .rdata(qdata),
		.full(full), .empty(qempty)
	);

	rmq_back u_back (
		.clk(clk), .arst_n(arst_n),
		.qdata(qdata), .qempty(qempty), .qpop(qpop),
		.pop(pop), .empty(empty),
		.quat_w(quat_w), .quat_x(quat_x), .quat_y(quat_y), .quat_z(quat_z),
		.degenerate(degenerate)
	);

endmodule

// ===== rtl/rmq_front.sv =====
// ----------------------------------------------------------------------------
// rmq_front
// Classify a matrix: pick the branch, the root argument and three sums or differences.
// ----------------------------------------------------------------------------
module rmq_front (
	input  logic signed [rmq_pkg::W-1:0] m00,
	input  logic signed [rmq_pkg::W-1:0] m01,
	input  logic signed [rmq_pkg::W-1:0] m02,
	input  logic signed [rmq_pkg::W-1:0] m10,
	input  logic signed [rmq_pkg::W-1:0] m11,
	input  logic signed [rmq_pkg::W-1:0] m12,
	input  logic signed [rmq_pkg::W-1:0] m20,
	input  logic signed [rmq_pkg::W-1:0] m21,
	input  logic signed [rmq_pkg::W-1:0] m22,
	output rmq_pkg::cls_t                cls
);
	localparam int SW = rmq_pkg::SUM_W;
	localparam int DW = rmq_pkg::D_W;

	logic signed [SW-1:0] a00, a11, a22, one, tr, arg0, arg1, arg2, arg_v;
	logic signed [DW-1:0] e01, e10, e02, e20, e12, e21;
	logic                 i1;
	logic [1:0]           isel;

	always_comb begin
		a00 = SW'(m00);
		a11 = SW'(m11);
		a22 = SW'(m22);
		one = SW'(1) <<< rmq_pkg::F;
		e01 = DW'(m01);
		e10 = DW'(m10);
		e02 = DW'(m02);
		e20 = DW'(m20);
		e12 = DW'(m12);
		e21 = DW'(m21);
		tr   = a00 + a11 + a22;
		arg0 = a00 - (a11 + a22) + one;
		arg1 = a11 - (a22 + a00) + one;
		arg2 = a22 - (a00 + a11) + one;
		// ties keep the lower index
		i1 = a11 > a00;
		if (a22 > (i1 ? a11 : a00)) begin
			isel = 2'd2;
		end else begin
			isel = i1 ? 2'd1 : 2'd0;
		end
		if (tr > 0) begin
			arg_v    = tr + one;
			cls.d0   = e12 - e21;
			cls.d1   = e20 - e02;
			cls.d2   = e01 - e10;
			cls.hsel = rmq_pkg::H_W;
		end else begin
			case (isel)
				2'd0: begin
					arg_v    = arg0;
					cls.d0   = e12 - e21;
					cls.d1   = e01 + e10;
					cls.d2   = e02 + e20;
					cls.hsel = rmq_pkg::H_X;
				end
				2'd1: begin
					arg_v    = arg1;
					cls.d0   = e20 - e02;
					cls.d1   = e10 + e01;
					cls.d2   = e12 + e21;
					cls.hsel = rmq_pkg::H_Y;
				end
				default: begin
					arg_v    = arg2;
					cls.d0   = e01 - e10;
					cls.d1   = e20 + e02;
					cls.d2   = e21 + e12;
					cls.hsel = rmq_pkg::H_Z;
				end
			endcase
		end
		// clamp a negative argument to zero
		if (arg_v <= 0) begin
			cls.arg = '0;
		end else begin
			cls.arg = arg_v[rmq_pkg::ARG_W-1:0];
		end
	end

endmodule

// ===== rtl/rmq_queue.sv =====
// ----------------------------------------------------------------------------
// rmq_queue
// Short queue of classified words between front and back.
// ----------------------------------------------------------------------------
`include "rotation_matrix_to_quaternion_top_assert.svh"
module rmq_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr,
	input  rmq_pkg::cls_t wdata,
	input  logic          rd,
	output rmq_pkg::cls_t rdata,
	output logic          full,
	output logic          empty
);
	rmq_pkg::cls_t                mem_q [rmq_pkg::QDEPTH];
	logic [rmq_pkg::QA_W-1:0]     wptr_q, rptr_q;
	logic [rmq_pkg::QA_W:0]       cnt_q;

	assign full  = cnt_q == (rmq_pkg::QA_W+1)'(rmq_pkg::QDEPTH);
	assign empty = cnt_q == '0;
	assign rdata = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (wr) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (rd) begin
				rptr_q <= rptr_q + 1'b1;
			end
			if (wr && !rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (rd && !wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	`RMQ_ASSERT(a_cnt_range, clk, arst_n, cnt_q <= (rmq_pkg::QA_W+1)'(rmq_pkg::QDEPTH), "queue count beyond depth")
	`RMQ_ASSERT_NEXT(a_cnt_inc, clk, arst_n, wr && !rd, cnt_q == $past(cnt_q) + 1'b1, "queue count missed a write")
	`RMQ_ASSERT(a_full_empty, clk, arst_n, !(full && empty), "queue full and empty together")

endmodule

// ===== rtl/rmq_back.sv =====
// ----------------------------------------------------------------------------
// rmq_back
// Root pipeline, one division pipeline shared by three words, routing and result register.
// ----------------------------------------------------------------------------
`include "rotation_matrix_to_quaternion_top_assert.svh"
module rmq_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  rmq_pkg::cls_t         qdata,
	input  logic                  qempty,
	output logic                  qpop,
	input  logic                  pop,
	output logic                  empty,
	output logic [rmq_pkg::W-1:0] quat_w,
	output logic [rmq_pkg::W-1:0] quat_x,
	output logic [rmq_pkg::W-1:0] quat_y,
	output logic [rmq_pkg::W-1:0] quat_z,
	output logic                  degenerate
);
	localparam int W  = rmq_pkg::W;
	localparam int N  = rmq_pkg::SQ_N;
	localparam int QB = rmq_pkg::QB;
	localparam int CW = rmq_pkg::CMP_W;
	localparam int SW = rmq_pkg::S_W;

	typedef struct packed {
		logic [rmq_pkg::RAD_W-1:0] rad;
		logic [rmq_pkg::REM_W-1:0] rem;
		logic [SW-1:0]             root;
		logic signed [rmq_pkg::D_W-1:0] d0;
		logic signed [rmq_pkg::D_W-1:0] d1;
		logic signed [rmq_pkg::D_W-1:0] d2;
		logic [1:0]                hsel;
	} sq_t;

	typedef struct packed {
		logic [CW-1:0]             r0;
		logic [CW-1:0]             r1;
		logic [CW-1:0]             r2;
		logic [QB-1:0]             q0;
		logic [QB-1:0]             q1;
		logic [QB-1:0]             q2;
		logic [2:0]                neg;
		logic [2:0]                ovf;
		logic [rmq_pkg::DEN_W-1:0] den;
		logic [W-1:0]              half;
		logic                      zero;
		logic [1:0]                hsel;
	} dv_t;

	logic         adv;
	logic         out_vld_q;
	logic [W-1:0] out_w_q, out_x_q, out_y_q, out_z_q;
	logic         out_degen_q;

	sq_t          sq_s [N+1];
	logic [N:0]   sq_vld_s;
	dv_t          dv_s [QB+1];
	logic [QB:0]  dv_vld_s;

	// hold everything while a finished word waits
	assign adv   = !out_vld_q || pop;
	assign qpop  = adv && !qempty;
	assign empty = !out_vld_q;

	always_ff @(posedge clk) begin
		if (adv) begin
			sq_s[0].rad  <= rmq_pkg::RAD_W'({qdata.arg, {rmq_pkg::F{1'b0}}});
			sq_s[0].rem  <= '0;
			sq_s[0].root <= '0;
			sq_s[0].d0   <= qdata.d0;
			sq_s[0].d1   <= qdata.d1;
			sq_s[0].d2   <= qdata.d2;
			sq_s[0].hsel <= qdata.hsel;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sq_vld_s <= '0;
			dv_vld_s <= '0;
		end else if (adv) begin
			sq_vld_s <= {sq_vld_s[N-1:0], qpop};
			dv_vld_s <= {dv_vld_s[QB-1:0], sq_vld_s[N]};
		end
	end

	// one root bit per stage
	for (genvar k = 0; k < N; k++) begin : g_sq
		logic [rmq_pkg::REM_W-1:0] rem2, trial;
		logic                      ge;
		sq_t                       nxt;
		always_comb begin
			rem2  = {sq_s[k].rem[rmq_pkg::REM_W-3:0],
				sq_s[k].rad[rmq_pkg::RAD_W-1 -: 2]};
			trial = rmq_pkg::REM_W'({sq_s[k].root, 2'b01});
			ge    = rem2 >= trial;
			nxt      = sq_s[k];
			nxt.rad  = sq_s[k].rad << 2;
			nxt.rem  = ge ? rem2 - trial : rem2;
			nxt.root = {sq_s[k].root[SW-2:0], ge};
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				sq_s[k+1] <= nxt;
			end
		end
	end

	// division set-up: numerators, divisor, overflow check, halved root
	logic [SW-1:0]             s_v;
	logic [rmq_pkg::DEN_W-1:0] den_v;
	logic [CW-1:0]             dlim, n0, n1, n2;
	logic [rmq_pkg::MAG_W-1:0] g0, g1, g2;
	logic [SW:0]               hs;
	dv_t                       prep;

	always_comb begin
		s_v   = sq_s[N].root;
		den_v = {s_v, 1'b0};
		dlim  = CW'(den_v) << QB;
		g0 = sq_s[N].d0[rmq_pkg::D_W-1] ? rmq_pkg::MAG_W'(-sq_s[N].d0)
			: rmq_pkg::MAG_W'(sq_s[N].d0);
		g1 = sq_s[N].d1[rmq_pkg::D_W-1] ? rmq_pkg::MAG_W'(-sq_s[N].d1)
			: rmq_pkg::MAG_W'(sq_s[N].d1);
		g2 = sq_s[N].d2[rmq_pkg::D_W-1] ? rmq_pkg::MAG_W'(-sq_s[N].d2)
			: rmq_pkg::MAG_W'(sq_s[N].d2);
		n0 = (CW'(g0) << rmq_pkg::F) + CW'(s_v);
		n1 = (CW'(g1) << rmq_pkg::F) + CW'(s_v);
		n2 = (CW'(g2) << rmq_pkg::F) + CW'(s_v);
		hs = ({1'b0, s_v} + 1'b1) >> 1;
		prep.r0   = n0;
		prep.r1   = n1;
		prep.r2   = n2;
		prep.q0   = '0;
		prep.q1   = '0;
		prep.q2   = '0;
		prep.neg  = {sq_s[N].d2[rmq_pkg::D_W-1], sq_s[N].d1[rmq_pkg::D_W-1],
			sq_s[N].d0[rmq_pkg::D_W-1]};
		prep.ovf  = {n2 >= dlim, n1 >= dlim, n0 >= dlim};
		prep.den  = den_v;
		prep.half = (hs > (SW+1)'(rmq_pkg::MAXV)) ? W'(rmq_pkg::MAXV) : W'(hs);
		prep.zero = s_v == '0;
		prep.hsel = sq_s[N].hsel;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dv_s[0] <= prep;
		end
	end

	// one quotient bit per stage for each of the three words
	for (genvar t = 0; t < QB; t++) begin : g_dv
		logic [CW-1:0] dsh;
		logic          ge0, ge1, ge2;
		dv_t           nxt;
		always_comb begin
			dsh = CW'(dv_s[t].den) << (QB - 1 - t);
			ge0 = dv_s[t].r0 >= dsh;
			ge1 = dv_s[t].r1 >= dsh;
			ge2 = dv_s[t].r2 >= dsh;
			nxt    = dv_s[t];
			nxt.r0 = ge0 ? dv_s[t].r0 - dsh : dv_s[t].r0;
			nxt.r1 = ge1 ? dv_s[t].r1 - dsh : dv_s[t].r1;
			nxt.r2 = ge2 ? dv_s[t].r2 - dsh : dv_s[t].r2;
			nxt.q0 = {dv_s[t].q0[QB-2:0], ge0};
			nxt.q1 = {dv_s[t].q1[QB-2:0], ge1};
			nxt.q2 = {dv_s[t].q2[QB-2:0], ge2};
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				dv_s[t+1] <= nxt;
			end
		end
	end

	// sign, saturation and routing
	localparam logic [W-1:0] VMAX = {1'b0, {(W-1){1'b1}}};
	localparam logic [W-1:0] VMIN = {1'b1, {(W-1){1'b0}}};

	logic [W-1:0] v0, v1, v2, rw, rx, ry, rz;
	dv_t          fin;

	always_comb begin
		fin = dv_s[QB];
		if (fin.zero) begin
			v0 = '0;
			v1 = '0;
			v2 = '0;
		end else begin
			v0 = fin.ovf[0] ? (fin.neg[0] ? VMIN : VMAX)
				: (fin.neg[0] ? -{1'b0, fin.q0} : {1'b0, fin.q0});
			v1 = fin.ovf[1] ? (fin.neg[1] ? VMIN : VMAX)
				: (fin.neg[1] ? -{1'b0, fin.q1} : {1'b0, fin.q1});
			v2 = fin.ovf[2] ? (fin.neg[2] ? VMIN : VMAX)
				: (fin.neg[2] ? -{1'b0, fin.q2} : {1'b0, fin.q2});
		end
		case (fin.hsel)
			rmq_pkg::H_W: begin
				rw = fin.half; rx = v0; ry = v1; rz = v2;
			end
			rmq_pkg::H_X: begin
				rw = v0; rx = fin.half; ry = v1; rz = v2;
			end
			rmq_pkg::H_Y: begin
				rw = v0; rx = v1; ry = fin.half; rz = v2;
			end
			default: begin
				rw = v0; rx = v1; ry = v2; rz = fin.half;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_w_q     <= rw;
			out_x_q     <= rx;
			out_y_q     <= ry;
			out_z_q     <= rz;
			out_degen_q <= fin.zero;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (adv) begin
			out_vld_q <= dv_vld_s[QB];
		end
	end

	assign quat_w     = out_w_q;
	assign quat_x     = out_x_q;
	assign quat_y     = out_y_q;
	assign quat_z     = out_z_q;
	assign degenerate = out_degen_q;

	`RMQ_ASSERT(a_degen_zero, clk, arst_n, (out_vld_q && out_degen_q) |-> (out_w_q == '0 && out_x_q == '0 && out_y_q == '0 && out_z_q == '0), "degenerate word with nonzero part")
	`RMQ_ASSERT_NEXT(a_stall_keep, clk, arst_n, !adv && dv_vld_s[QB], dv_vld_s[QB], "word lost in stalled pipeline")
	`RMQ_ASSERT(a_out_origin, clk, arst_n, $rose(out_vld_q) |-> $past(dv_vld_s[QB]), "result word from nowhere")

endmodule
